>>> design/cwc_pkg.sv
// Shared types and constants for the congestion window controller.
// Used by cwc_state and congestion_window_controller; no dependencies.
package cwc_pkg;

    localparam int WINDOW_BITS = 16;
    localparam int THR_BITS    = 16;
    localparam int ACK_BITS    = 31;
    localparam int OUT_WIN_BITS = 16;

    localparam logic [WINDOW_BITS-1:0] WIN_MAX  = {WINDOW_BITS{1'b1}};
    localparam logic [WINDOW_BITS-1:0] WIN_ONE  = WINDOW_BITS'(1);
    localparam logic [THR_BITS-1:0]    THR_MAX  = {THR_BITS{1'b1}};
    localparam logic [THR_BITS-1:0]    THR_MIN  = THR_BITS'(2);
    localparam logic [THR_BITS-1:0]    THR_RESET = THR_BITS'(64);
    localparam logic [31:0]            SMALL_WIN_LIMIT = 32'd4;

    localparam logic ACT_ACK  = 1'b0;
    localparam logic ACT_LOSS = 1'b1;

    typedef enum logic [1:0] {
        MODE_SLOW    = 2'd0,
        MODE_AVOID   = 2'd1,
        MODE_RECOVER = 2'd2
    } mode_t;

    typedef struct packed {
        logic                action;
        logic [ACK_BITS-1:0] ack_number;
    } event_t;

    typedef struct packed {
        logic                    window_recorded;
        logic [1:0]              mode;
        logic [THR_BITS-1:0]     threshold;
        logic [OUT_WIN_BITS-1:0] window_size;
    } result_t;

    function automatic logic [WINDOW_BITS-1:0] win_inc(input logic [WINDOW_BITS-1:0] w);
        return (w == WIN_MAX) ? WIN_MAX : w + WIN_ONE;
    endfunction

endpackage

>>> design/cwc_state.sv
// Connection state registers and the per-request update logic.
// Depends on cwc_pkg.
module cwc_state
    import cwc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_write,
    input  logic [THR_BITS-1:0] cfg_data,
    input  logic                advance,
    input  event_t              evt,
    output result_t             result
);

    logic [WINDOW_BITS-1:0] window_reg, window_next;
    logic [THR_BITS-1:0]    threshold_reg, threshold_next;
    mode_t                  mode_reg, mode_next;
    logic [WINDOW_BITS-1:0] round_reg, round_next;
    logic [ACK_BITS-1:0]    mark_reg, mark_next;
    logic                   recorded;
    logic [WINDOW_BITS-1:0] win_plus;
    logic [WINDOW_BITS-1:0] round_plus;
    logic [31:0]            half_ext;
    logic [31:0]            win_ext;
    logic [31:0]            out_win_ext;

    assign win_plus   = win_inc(window_reg);
    assign round_plus = win_inc(round_reg);
    assign win_ext    = 32'(window_reg);
    assign half_ext   = 32'(window_reg >> 1);

    always_comb begin
        window_next    = window_reg;
        threshold_next = threshold_reg;
        mode_next      = mode_reg;
        round_next     = round_reg;
        mark_next      = mark_reg;
        recorded       = 1'b0;
        if (evt.action == ACT_LOSS) begin
            mark_next = evt.ack_number;
            if (win_ext > SMALL_WIN_LIMIT) begin
                threshold_next = (half_ext > 32'(THR_MAX)) ? THR_MAX : half_ext[THR_BITS-1:0];
            end else begin
                threshold_next = THR_MIN;
            end
            window_next = WIN_ONE;
            mode_next   = MODE_RECOVER;
            recorded    = 1'b1;
        end else begin
            unique case (mode_reg)
                MODE_SLOW: begin
                    window_next = win_plus;
                    recorded    = 1'b1;
                    if (32'(win_plus) >= 32'(threshold_reg)) begin
                        mode_next = MODE_AVOID;
                    end
                end
                MODE_AVOID: begin
                    round_next = round_plus;
                    if (round_plus >= window_reg) begin
                        window_next = win_plus;
                        round_next  = '0;
                        recorded    = 1'b1;
                    end
                end
                MODE_RECOVER: begin
                    window_next = win_plus;
                    if (evt.ack_number > mark_reg) begin
                        mode_next = MODE_SLOW;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign out_win_ext            = 32'(window_next);
    assign result.window_size     = out_win_ext[OUT_WIN_BITS-1:0];
    assign result.threshold       = threshold_next;
    assign result.mode            = mode_next;
    assign result.window_recorded = recorded;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg    <= WIN_ONE;
            threshold_reg <= THR_RESET;
            mode_reg      <= MODE_SLOW;
            round_reg     <= '0;
            mark_reg      <= '0;
        end else if (cfg_write) begin
            threshold_reg <= cfg_data;
        end else if (advance) begin
            window_reg    <= window_next;
            threshold_reg <= threshold_next;
            mode_reg      <= mode_next;
            round_reg     <= round_next;
            mark_reg      <= mark_next;
        end
    end

    a_loss_resets_window: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !cfg_write && evt.action == ACT_LOSS
        |=> window_reg == WIN_ONE && mode_reg == MODE_RECOVER)
        else $error("loss did not reset the window");

    a_small_loss_threshold: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !cfg_write && evt.action == ACT_LOSS && win_ext <= SMALL_WIN_LIMIT
        |=> threshold_reg == THR_MIN)
        else $error("threshold after a small-window loss is not two");

    a_window_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        window_reg != '0)
        else $error("window reached zero");

    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance && !cfg_write
        |=> $stable(window_reg) && $stable(mode_reg) && $stable(round_reg))
        else $error("state changed without a request");

endmodule

>>> design/congestion_window_controller.sv
// Top level of the congestion window controller: input register, output register
// and the handshakes around them. Depends on cwc_pkg and cwc_state.
//
//  Channel   Direction  Handshake             Contents
//  s_        in         s_tvalid / s_tready   one event request
//  m_        out        m_tvalid / m_tready   one result per event
//  cfg_      in         cfg_valid / cfg_ready initial slow start threshold
//
// A request is registered on entry, evaluated against the state when the output register
// can take it and lands there; one request per cycle while the output is not stalled.
// The state update happens with the output register load, unless a cfg write takes priority.
// A stalled output holds its result and the input register keeps one more request.
// Reset is synchronous and active low; the configuration port is always ready.
module congestion_window_controller
    import cwc_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // [30:0] ack_number, [31] unused
    input  logic                s_tuser,   // [0] action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [15:0] window_size, [31:16] threshold,
                                           // [33:32] mode, [34] window_recorded, [39:35] zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [THR_BITS-1:0] cfg_data
);

    logic    in_valid_reg, in_valid_next;
    event_t  in_evt_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;
    result_t result;
    logic    advance;
    logic    s_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign in_valid_next  = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
    assign out_valid_next = advance ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_evt_reg.action     <= s_tuser;
            in_evt_reg.ack_number <= s_tdata[ACK_BITS-1:0];
        end
        if (advance) begin
            out_res_reg <= result;
        end
    end

    cwc_state u_state (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .advance  (advance),
        .evt      (in_evt_reg),
        .result   (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_res_reg};

endmodule
